// File: rtl/core/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg: shared types and constants of the bitmap first-fit allocator
// Holds the map word geometry, the header size, the operation codes, the
// controller states and the command bundle sent to the bitmap store.
// ----------------------------------------------------------------------------
package bfa_pkg;

    // Bitmap store word: one bit per block, sixteen blocks per word.
    localparam int MAP_W     = 16;
    localparam int MAP_SHIFT = 4;

    // Header placed in front of every allocation.
    localparam int HDR_BYTES = 4;

    // Width of a recorded allocation length in bytes (header included).
    localparam int LEN_W  = 17;
    localparam int ADDR_W = 32;
    localparam int FB_W   = 10;

    // Operation codes carried on func.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Word index of the base address register on the APB port.
    localparam logic CFG_IDX_BASE = 1'b0;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NEED,
        ST_SCAN,
        ST_IDX,
        ST_LEN,
        ST_COUNT,
        ST_MARK
    } bfa_state_t;

    // Command to the bitmap store for one cycle.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wipe;
        logic set;
    } map_cmd_t;

endpackage

// File: rtl/core/bfa_div.sv
// ----------------------------------------------------------------------------
// bfa_div: division by the fixed block size
// The block size is a power of two, so the quotient is a right shift. It is
// registered and is ready, with done high, in the cycle after start.
// ----------------------------------------------------------------------------
module bfa_div
    import bfa_pkg::*;
#(
    parameter int DIVISOR = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ADDR_W-1:0] dividend,
    output logic              done,
    output logic [ADDR_W-1:0] quotient
);

    localparam int SHIFT = $clog2(DIVISOR);

    logic              done_reg;
    logic              done_next;
    logic [ADDR_W-1:0] quo_reg;
    logic [ADDR_W-1:0] quo_next;

    always_comb
    begin
        done_next = start;
        quo_next  = quo_reg;
        if (start)
        begin
            quo_next = dividend >> SHIFT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/core/bfa_map.sv
// ----------------------------------------------------------------------------
// bfa_map: used/free bitmap store
// Sixteen block bits per word, one registered read and one write per cycle.
// A write either wipes the word or sets or clears the bits that fall inside
// the block range lo..hi, applied to the word read in the previous cycle.
// ----------------------------------------------------------------------------
module bfa_map
    import bfa_pkg::*;
#(
    parameter int WORDS = 64,
    parameter int WA    = 6,
    parameter int BI    = 10
)
(
    input  logic             clk,
    input  map_cmd_t         cmd,
    input  logic [WA-1:0]    rd_addr,
    input  logic [WA-1:0]    wr_addr,
    input  logic [BI-1:0]    lo,
    input  logic [BI-1:0]    hi,
    output logic [MAP_W-1:0] rd_data
);

    logic [MAP_W-1:0] mem [WORDS];
    logic [MAP_W-1:0] rd_data_reg;
    logic [MAP_W-1:0] mask;
    logic [MAP_W-1:0] wr_data;

    always_comb
    begin
        for (int j = 0; j < MAP_W; j++)
        begin
            mask[j] = (((32'(wr_addr) << MAP_SHIFT) | 32'(j)) >= 32'(lo)) &&
                      (((32'(wr_addr) << MAP_SHIFT) | 32'(j)) <= 32'(hi));
        end
        if (cmd.wipe)
        begin
            wr_data = '0;
        end
        else if (cmd.set)
        begin
            wr_data = rd_data_reg | mask;
        end
        else
        begin
            wr_data = rd_data_reg & ~mask;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/bfa_scan.sv
// ----------------------------------------------------------------------------
// bfa_scan: first-fit run finder over one bitmap word per cycle
// Carries the length of the free run that ends at the previous word and
// reports the lowest bit of this word at which a run reaches the need.
// ----------------------------------------------------------------------------
module bfa_scan
    import bfa_pkg::*;
#(
    parameter int NUM_BLOCKS = 1024,
    parameter int WA         = 6,
    parameter int BI         = 10,
    parameter int CW         = 11
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             restart,
    input  logic             word_valid,
    input  logic [MAP_W-1:0] word_data,
    input  logic [WA-1:0]    word_idx,
    input  logic [CW-1:0]    need,
    output logic             hit,
    output logic [BI-1:0]    hit_start
);

    localparam int RXW = CW + MAP_SHIFT + 1;

    logic [CW-1:0]    run_reg;
    logic [CW-1:0]    run_next;
    logic [MAP_W-1:0] used;
    logic [RXW-1:0]   run_ext [MAP_W];
    logic [MAP_W-1:0] fit;
    logic [3:0]       hit_bit;

    always_comb
    begin
        logic found;
        logic [3:0] last;
        // Blocks past the end of the region count as used.
        for (int j = 0; j < MAP_W; j++)
        begin
            used[j] = word_data[j] ||
                      (((32'(word_idx) << MAP_SHIFT) | 32'(j)) >= 32'(NUM_BLOCKS));
        end
        for (int j = 0; j < MAP_W; j++)
        begin
            found = 1'b0;
            last  = '0;
            for (int k = 0; k <= j; k++)
            begin
                if (used[k])
                begin
                    found = 1'b1;
                    last  = 4'(k);
                end
            end
            if (found)
            begin
                run_ext[j] = RXW'(4'(j) - last);
            end
            else
            begin
                run_ext[j] = RXW'(run_reg) + RXW'(j + 1);
            end
            fit[j] = run_ext[j] >= RXW'(need);
        end
        hit     = 1'b0;
        hit_bit = '0;
        for (int j = MAP_W - 1; j >= 0; j--)
        begin
            if (fit[j] && word_valid)
            begin
                hit     = 1'b1;
                hit_bit = 4'(j);
            end
        end
        hit_start = BI'(((32'(word_idx) << MAP_SHIFT) | 32'(hit_bit)) + 32'd1 - 32'(need));
        run_next  = run_reg;
        if (restart)
        begin
            run_next = '0;
        end
        else if (word_valid)
        begin
            run_next = CW'(run_ext[MAP_W-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

endmodule

// File: rtl/core/bitmap_first_fit_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator: first-fit block allocator over a used/free map
// Allocates and frees runs of fixed-size blocks with a four-byte length
// header in front of each allocation.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// transfer appears on ok, granted_address and first_block for exactly one
// cycle with done high, and the receiver cannot stall it, so it must capture
// the result in that cycle. Commands are handled one at a time. BLOCK_BYTES
// must be a power of two, so that turning bytes into blocks is a registered
// shift. An allocate first turns the byte count into a block count, then
// scans the bitmap store one word of sixteen blocks per cycle, stopping
// early when a run is found, then reads and writes back every word that
// the run touches at one word per cycle; done follows in the next cycle. A
// request for more blocks than the region holds ends as soon as its block
// count is known. A free turns the address into a block index, reads the
// recorded length, turns it into a block count and then does the same word
// write-back as an allocate. busy is low in the cycle that carries done, so
// the next command can be taken there. After reset the block clears the
// bitmap store one word per cycle and keeps busy high meanwhile; the base
// address register can be written at any time over the APB port, but should
// only change while no command is in flight.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator
    import bfa_pkg::*;
#(
    parameter int NUM_BLOCKS  = 1024,
    parameter int BLOCK_BYTES = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    // Command channel
    input  logic              start,
    output logic              busy,
    input  logic              func,
    input  logic [15:0]       request_size,
    input  logic [ADDR_W-1:0] release_address,
    // Result channel
    output logic              done,
    output logic              ok,
    output logic [ADDR_W-1:0] granted_address,
    output logic [FB_W-1:0]   first_block,
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int WORDS = (NUM_BLOCKS + MAP_W - 1) / MAP_W;
    localparam int WA    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BI    = $clog2(NUM_BLOCKS);
    localparam int CW    = $clog2(NUM_BLOCKS + 1);

    bfa_state_t        state_reg;
    bfa_state_t        state_next;
    logic              op_reg;
    logic              op_next;
    logic [LEN_W-1:0]  act_reg;
    logic [LEN_W-1:0]  act_next;
    logic [CW-1:0]     need_reg;
    logic [CW-1:0]     need_next;
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] idx_next;
    logic [BI-1:0]     lo_reg;
    logic [BI-1:0]     lo_next;
    logic [BI-1:0]     hi_reg;
    logic [BI-1:0]     hi_next;
    logic [WA:0]       rd_ptr_reg;
    logic [WA:0]       rd_ptr_next;
    logic [WA-1:0]     ev_ptr_reg;
    logic [WA-1:0]     ev_ptr_next;
    logic              rd_valid_reg;
    logic              rd_valid_next;
    logic [ADDR_W-1:0] base_reg;
    logic              done_reg;
    logic              done_next;
    logic              ok_reg;
    logic              ok_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;
    logic [FB_W-1:0]   fb_reg;
    logic [FB_W-1:0]   fb_next;

    logic              div_start;
    logic [ADDR_W-1:0] div_dividend;
    logic              div_done;
    logic [ADDR_W-1:0] div_quotient;

    map_cmd_t          map_cmd;
    logic [WA-1:0]     map_rd_addr;
    logic [WA-1:0]     map_wr_addr;
    logic [MAP_W-1:0]  map_rd_data;

    logic              scan_restart;
    logic              scan_valid;
    logic              scan_hit;
    logic [BI-1:0]     scan_start;

    // Recorded allocation lengths, one entry per block.
    logic [LEN_W-1:0]  len_mem [NUM_BLOCKS];
    logic [LEN_W-1:0]  len_rd_reg;
    logic              len_we;
    logic              len_re;
    logic [BI-1:0]     len_ra;

    logic              cfg_write;
    logic [ADDR_W-1:0] span_end;
    logic [WA:0]       hi_word;

    // ------------------------------------------------------------------
    // Configuration port: single base address register, no wait states.
    // ------------------------------------------------------------------
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == CFG_IDX_BASE) ? base_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_write && (paddr[2] == CFG_IDX_BASE))
        begin
            base_reg <= pwdata;
        end
    end

    // ------------------------------------------------------------------
    // Sub-units
    // ------------------------------------------------------------------
    bfa_div #(
        .DIVISOR (BLOCK_BYTES)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_quotient)
    );

    bfa_map #(
        .WORDS (WORDS),
        .WA    (WA),
        .BI    (BI)
    ) u_map (
        .clk     (clk),
        .cmd     (map_cmd),
        .rd_addr (map_rd_addr),
        .wr_addr (map_wr_addr),
        .lo      (lo_reg),
        .hi      (hi_reg),
        .rd_data (map_rd_data)
    );

    bfa_scan #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .WA         (WA),
        .BI         (BI),
        .CW         (CW)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (scan_restart),
        .word_valid (scan_valid),
        .word_data  (map_rd_data),
        .word_idx   (ev_ptr_reg),
        .need       (need_reg),
        .hit        (scan_hit),
        .hit_start  (scan_start)
    );

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[scan_start] <= act_reg;
        end
        if (len_re)
        begin
            len_rd_reg <= len_mem[len_ra];
        end
    end

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    // Last block of a free run, before clipping at the end of the region.
    assign span_end = idx_reg + div_quotient - 32'd1;
    assign hi_word  = (WA + 1)'(hi_reg >> MAP_SHIFT);

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        act_next      = act_reg;
        need_next     = need_reg;
        idx_next      = idx_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        rd_ptr_next   = rd_ptr_reg;
        ev_ptr_next   = ev_ptr_reg;
        rd_valid_next = 1'b0;
        done_next     = 1'b0;
        ok_next       = ok_reg;
        addr_next     = addr_reg;
        fb_next       = fb_reg;
        div_start     = 1'b0;
        div_dividend  = '0;
        map_cmd       = '0;
        map_rd_addr   = rd_ptr_reg[WA-1:0];
        map_wr_addr   = ev_ptr_reg;
        scan_restart  = 1'b0;
        scan_valid    = 1'b0;
        len_we        = 1'b0;
        len_re        = 1'b0;
        len_ra        = div_quotient[BI-1:0];

        case (state_reg)
            ST_CLEAR:
            begin
                // Post-reset sweep: every map word is written to all free.
                map_cmd.wr_en = 1'b1;
                map_cmd.wipe  = 1'b1;
                map_wr_addr   = rd_ptr_reg[WA-1:0];
                if (rd_ptr_reg == (WA + 1)'(WORDS - 1))
                begin
                    rd_ptr_next = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    op_next   = func;
                    act_next  = LEN_W'(request_size) + LEN_W'(HDR_BYTES);
                    div_start = 1'b1;
                    if (func == FUNC_ALLOC)
                    begin
                        // Round the length with header up to whole blocks.
                        div_dividend = ADDR_W'(request_size) + ADDR_W'(HDR_BYTES) +
                                       ADDR_W'(BLOCK_BYTES - 1);
                        state_next   = ST_NEED;
                    end
                    else
                    begin
                        div_dividend = release_address - ADDR_W'(HDR_BYTES) - base_reg;
                        state_next   = ST_IDX;
                    end
                end
            end

            ST_NEED:
            begin
                if (div_done)
                begin
                    if (div_quotient > ADDR_W'(NUM_BLOCKS))
                    begin
                        done_next  = 1'b1;
                        ok_next    = 1'b0;
                        addr_next  = '0;
                        fb_next    = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        need_next    = CW'(div_quotient);
                        rd_ptr_next  = '0;
                        scan_restart = 1'b1;
                        state_next   = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Reads run one word ahead of the evaluation.
                if (rd_ptr_reg < (WA + 1)'(WORDS))
                begin
                    map_cmd.rd_en = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_ptr_next   = rd_ptr_reg + 1'b1;
                end
                ev_ptr_next = rd_ptr_reg[WA-1:0];
                scan_valid  = rd_valid_reg;
                if (rd_valid_reg && scan_hit)
                begin
                    len_we        = 1'b1;
                    lo_next       = scan_start;
                    hi_next       = BI'(32'(scan_start) + 32'(need_reg) - 32'd1);
                    rd_ptr_next   = (WA + 1)'(scan_start >> MAP_SHIFT);
                    rd_valid_next = 1'b0;
                    state_next    = ST_MARK;
                end
                else if (rd_valid_reg && (ev_ptr_reg == WA'(WORDS - 1)))
                begin
                    done_next     = 1'b1;
                    ok_next       = 1'b0;
                    addr_next     = '0;
                    fb_next       = '0;
                    rd_valid_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end

            ST_IDX:
            begin
                if (div_done)
                begin
                    idx_next = div_quotient;
                    if (div_quotient >= ADDR_W'(NUM_BLOCKS))
                    begin
                        // Address outside the region: nothing to release.
                        done_next  = 1'b1;
                        ok_next    = 1'b0;
                        addr_next  = '0;
                        fb_next    = div_quotient[FB_W-1:0];
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        len_re     = 1'b1;
                        state_next = ST_LEN;
                    end
                end
            end

            ST_LEN:
            begin
                div_start    = 1'b1;
                div_dividend = ADDR_W'(len_rd_reg) + ADDR_W'(BLOCK_BYTES - 1);
                state_next   = ST_COUNT;
            end

            ST_COUNT:
            begin
                if (div_done)
                begin
                    if (div_quotient == '0)
                    begin
                        done_next  = 1'b1;
                        ok_next    = 1'b1;
                        addr_next  = '0;
                        fb_next    = idx_reg[FB_W-1:0];
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // A run that reaches past the region is clipped at its end.
                        lo_next = BI'(idx_reg);
                        if (span_end >= ADDR_W'(NUM_BLOCKS - 1))
                        begin
                            hi_next = BI'(NUM_BLOCKS - 1);
                        end
                        else
                        begin
                            hi_next = BI'(span_end);
                        end
                        rd_ptr_next = (WA + 1)'(BI'(idx_reg) >> MAP_SHIFT);
                        state_next  = ST_MARK;
                    end
                end
            end

            ST_MARK:
            begin
                // Read-modify-write of each word the run touches.
                if (rd_ptr_reg <= hi_word)
                begin
                    map_cmd.rd_en = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_ptr_next   = rd_ptr_reg + 1'b1;
                end
                ev_ptr_next = rd_ptr_reg[WA-1:0];
                if (rd_valid_reg)
                begin
                    map_cmd.wr_en = 1'b1;
                    map_cmd.set   = (op_reg == FUNC_ALLOC);
                    if ((WA + 1)'(ev_ptr_reg) == hi_word)
                    begin
                        rd_valid_next = 1'b0;
                        done_next     = 1'b1;
                        ok_next       = 1'b1;
                        state_next    = ST_IDLE;
                        if (op_reg == FUNC_ALLOC)
                        begin
                            addr_next = base_reg + 32'(lo_reg) * 32'(BLOCK_BYTES) +
                                        32'(HDR_BYTES);
                            fb_next   = FB_W'(lo_reg);
                        end
                        else
                        begin
                            addr_next = '0;
                            fb_next   = idx_reg[FB_W-1:0];
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            rd_ptr_reg   <= '0;
            rd_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_ptr_reg   <= rd_ptr_next;
            rd_valid_reg <= rd_valid_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        act_reg    <= act_next;
        need_reg   <= need_next;
        idx_reg    <= idx_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        ev_ptr_reg <= ev_ptr_next;
        ok_reg     <= ok_next;
        addr_reg   <= addr_next;
        fb_reg     <= fb_next;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign ok              = ok_reg;
    assign granted_address = addr_reg;
    assign first_block     = fb_reg;

endmodule

// File: test/bitmap_first_fit_allocator_tb.sv
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator_tb: self-checking bench for the block allocator
// Drives allocate and free commands with bursty timing. It predicts every
// result transfer from a private copy of the used/free map and the recorded
// lengths, and compares each result field by field. The base address is
// changed between phases over the APB port.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator_tb
    import bfa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BLOCKS     = 1024;
    localparam int BLOCK_BYTES    = 32;
    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 9;
    // Covers the slowest command, an allocate of the whole region, plus the
    // longest sender gap, the final drain and the clearing pass after reset,
    // with margin.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int REPORT_LIMIT   = 10;

    // The base address register is word 0, hence byte address 0.
    localparam logic [2:0] BASE_PADDR = {CFG_IDX_BASE, 2'b00};

    // One result transfer as the block presents it.
    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] addr;
        logic [FB_W-1:0]   fb;
    } outcome_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              func;
    logic [15:0]       request_size;
    logic [ADDR_W-1:0] release_address;
    logic              done;
    logic              ok;
    logic [ADDR_W-1:0] granted_address;
    logic [FB_W-1:0]   first_block;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // Private copy of the allocator state used for prediction.
    bit                blk_used    [NUM_BLOCKS];
    logic [LEN_W-1:0]  blk_len     [NUM_BLOCKS];
    bit                blk_written [NUM_BLOCKS];
    logic [ADDR_W-1:0] cur_base = '0;

    // Expected result transfers, oldest first.
    outcome_t pending_outcomes[$];

    // Stimulus bookkeeping: first blocks of allocations believed to be live,
    // and every block that has ever held an allocation header. Only the
    // latter are the target of a random free that falls inside the region,
    // as the length store of any other block is undefined.
    int live_blocks[$];
    int written_blocks[$];

    // Sender idling: bursts of random length separated by random gaps.
    int idle_gap_max = 0;
    int burst_left   = 0;

    int mismatch_count = 0;
    int idle_cycles    = 0;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    bitmap_first_fit_allocator #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .func            (func),
        .request_size    (request_size),
        .release_address (release_address),
        .done            (done),
        .ok              (ok),
        .granted_address (granted_address),
        .first_block     (first_block),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Index of the block that holds the header in front of an address. All
    // address arithmetic wraps modulo 2^32.
    function automatic logic [ADDR_W-1:0] header_block(input logic [ADDR_W-1:0] rel);
        return (rel - ADDR_W'(HDR_BYTES) - cur_base) / ADDR_W'(BLOCK_BYTES);
    endfunction

    // Address that an allocation starting at the given block is granted.
    function automatic logic [ADDR_W-1:0] block_addr(input int blk);
        return cur_base + ADDR_W'(blk * BLOCK_BYTES) + ADDR_W'(HDR_BYTES);
    endfunction

    // Applies one accepted command to the private state and returns the
    // result transfer that the block should produce for it.
    function automatic outcome_t compute_outcome(input logic f, input logic [15:0] sz,
                                                 input logic [ADDR_W-1:0] rel);
        outcome_t          res;
        logic [LEN_W-1:0]  act;
        logic [ADDR_W-1:0] idx;
        int                need;
        int                run;
        int                first;
        int                hb;
        int                n;
        int                i;
        res = '0;
        if (f == FUNC_ALLOC)
        begin
            // The header is counted in the length, then rounded up to blocks.
            act   = LEN_W'(sz) + LEN_W'(HDR_BYTES);
            need  = (int'(act) + BLOCK_BYTES - 1) / BLOCK_BYTES;
            run   = 0;
            first = 0;
            if (need <= NUM_BLOCKS)
            begin
                // First fit: any used block breaks the run being counted.
                for (i = 0; i < NUM_BLOCKS && run < need; i++)
                begin
                    if (blk_used[i])
                    begin
                        run = 0;
                    end
                    else
                    begin
                        if (run == 0)
                            first = i;
                        run++;
                    end
                end
            end
            if (run == need)
            begin
                for (i = first; i < first + need; i++)
                    blk_used[i] = 1'b1;
                blk_len[first] = act;
                if (!blk_written[first])
                begin
                    blk_written[first] = 1'b1;
                    written_blocks.push_back(first);
                end
                res.ok   = 1'b1;
                res.addr = block_addr(first);
                res.fb   = FB_W'(first);
            end
        end
        else
        begin
            // A free outside the region changes nothing but still reports
            // the low bits of the computed index.
            idx    = header_block(rel);
            res.fb = idx[FB_W-1:0];
            if (idx < NUM_BLOCKS)
            begin
                hb = int'(idx);
                n  = (int'(blk_len[hb]) + BLOCK_BYTES - 1) / BLOCK_BYTES;
                for (i = 0; i < n && hb + i < NUM_BLOCKS; i++)
                    blk_used[hb + i] = 1'b0;
                res.ok = 1'b1;
            end
        end
        return res;
    endfunction

    // Sends one command and records its expected result once the transfer
    // has been accepted. The task is entered and left at a rising edge, and
    // start is left high so that back-to-back commands need no idle cycle.
    task automatic send_cmd(input logic f, input logic [15:0] sz,
                            input logic [ADDR_W-1:0] rel);
        outcome_t res;
        int       gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (idle_gap_max > 0)
                gap = $urandom_range(1, idle_gap_max);
        end
        burst_left--;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start           <= 1'b1;
        func            <= f;
        request_size    <= sz;
        release_address <= rel;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        res = compute_outcome(f, sz, rel);
        pending_outcomes.push_back(res);
        if (f == FUNC_ALLOC && res.ok)
            live_blocks.push_back(int'(res.fb));
    endtask

    // Drops start and waits until every expected result has arrived and the
    // block reports itself idle.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_outcomes.size() != 0 || busy !== 1'b0)
            @(posedge clk);
    endtask

    // Writes the base address with a setup and an access cycle.
    task automatic write_base(input logic [31:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BASE_PADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        cur_base  = value;
    endtask

    // Boundary sizes, failures, first-fit reuse, misaligned and double
    // frees, frees outside the region and a completely full map. Expects a
    // freshly cleared map.
    task automatic test_directed();
        send_cmd(FUNC_ALLOC, 16'd0, '0);
        // Exactly one block once the header is added, then one byte over.
        send_cmd(FUNC_ALLOC, 16'(BLOCK_BYTES - HDR_BYTES), '1);
        send_cmd(FUNC_ALLOC, 16'(BLOCK_BYTES - HDR_BYTES + 1), '0);
        // Larger than the whole region, then the whole region while taken.
        send_cmd(FUNC_ALLOC, 16'hFFFF, '1);
        send_cmd(FUNC_ALLOC, 16'(NUM_BLOCKS * BLOCK_BYTES - HDR_BYTES), '0);
        // The hole left at block 1 must be the one that is reused.
        send_cmd(FUNC_FREE, 16'hFFFF, block_addr(1));
        send_cmd(FUNC_ALLOC, 16'd0, '0);
        // Misaligned free into block 2, which the two-block allocation once covered, then a second free of block 2.
        send_cmd(FUNC_FREE, '0, block_addr(2) + 32'd17);
        send_cmd(FUNC_FREE, '0, block_addr(2));
        // Below the base, just past the region and at the top of the space.
        send_cmd(FUNC_FREE, '0, cur_base);
        send_cmd(FUNC_FREE, '0, block_addr(NUM_BLOCKS));
        send_cmd(FUNC_FREE, '0, '1);
        send_cmd(FUNC_FREE, '0, block_addr(0));
        send_cmd(FUNC_FREE, '0, block_addr(1));
        // A run that fills the map, a failure on the full map, and release.
        send_cmd(FUNC_ALLOC, 16'(NUM_BLOCKS * BLOCK_BYTES - HDR_BYTES), '0);
        send_cmd(FUNC_ALLOC, 16'd0, '1);
        send_cmd(FUNC_FREE, '0, block_addr(0));
        // Leave only the last block free so it is granted on its own.
        send_cmd(FUNC_ALLOC, 16'((NUM_BLOCKS - 1) * BLOCK_BYTES - HDR_BYTES), '0);
        send_cmd(FUNC_ALLOC, 16'd0, '1);
        send_cmd(FUNC_FREE, '0, block_addr(NUM_BLOCKS - 1));
        send_cmd(FUNC_FREE, '0, block_addr(0));
        live_blocks.delete();
    endtask

    // Mostly well-formed traffic: allocations of mostly small sizes and
    // frees of live allocations, with misaligned, repeated and stray frees
    // mixed in. Stray frees that land on a block that never held a header
    // are redirected to one that did.
    task automatic test_random(input int count);
        logic [15:0]       sz;
        logic [ADDR_W-1:0] rel;
        logic [ADDR_W-1:0] idx;
        int                n;
        int                roll;
        int                slot;
        for (n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            rel  = $urandom;
            sz   = 16'($urandom);
            if (live_blocks.size() == 0 || roll < 50)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    sz = 16'($urandom_range(0, 120));
                else if (roll < 90)
                    sz = 16'($urandom_range(0, 1000));
                else if (roll < 97)
                    sz = 16'($urandom_range(0, 8000));
                send_cmd(FUNC_ALLOC, sz, rel);
            end
            else if (roll < 85)
            begin
                slot = $urandom_range(0, live_blocks.size() - 1);
                rel  = block_addr(live_blocks[slot]);
                live_blocks.delete(slot);
                send_cmd(FUNC_FREE, sz, rel);
            end
            else if (roll < 93)
            begin
                slot = $urandom_range(0, written_blocks.size() - 1);
                rel  = block_addr(written_blocks[slot]) +
                       ADDR_W'($urandom_range(0, BLOCK_BYTES - 1));
                send_cmd(FUNC_FREE, sz, rel);
            end
            else
            begin
                // Half of the stray frees fall in the region or within 128 bytes of it.
                if ($urandom_range(0, 1) == 0)
                    rel = cur_base + ADDR_W'($urandom_range(0, NUM_BLOCKS * BLOCK_BYTES + 255))
                          - ADDR_W'(128);
                idx = header_block(rel);
                if (idx < NUM_BLOCKS && !blk_written[int'(idx)])
                begin
                    slot = $urandom_range(0, written_blocks.size() - 1);
                    rel  = block_addr(written_blocks[slot]);
                end
                send_cmd(FUNC_FREE, sz, rel);
            end
        end
    endtask

    task automatic note_mismatch(input string what, input outcome_t want, input outcome_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%t mismatch (%s): expected ok=%0b addr=%h fb=%0d, %s",
                     $realtime, what, want.ok, want.addr, want.fb,
                     $sformatf("got ok=%0b addr=%h fb=%0d", got.ok, got.addr, got.fb));
    endtask

    // Result checking and the watchdog. Every result transfer is taken at
    // the edge that ends its cycle, as the receiver cannot stall the block.
    always @(posedge clk)
    begin
        outcome_t want;
        outcome_t got;
        if (rst_n === 1'b1)
        begin
            if (done === 1'b1)
            begin
                got = {ok, granted_address, first_block};
                if (pending_outcomes.size() == 0)
                begin
                    note_mismatch("no result expected", '0, got);
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (got.ok !== want.ok || got.addr !== want.addr || got.fb !== want.fb)
                        note_mismatch("result", want, got);
                end
            end
            if (done === 1'b1 || (start === 1'b1 && busy === 1'b0))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("bitmap_first_fit_allocator_tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n           <= 1'b0;
        start           <= 1'b0;
        func            <= FUNC_ALLOC;
        request_size    <= '0;
        release_address <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The block clears its map after reset; write_base waits for that.
        write_base(32'h0000_0000);
        idle_gap_max = 40;
        test_directed();

        // Top of the address space: every granted address wraps.
        write_base(32'hFFFF_FFFF);
        idle_gap_max = 0;
        test_random(300);

        // Long gaps so that new commands meet every stage of the previous one.
        write_base(32'h8000_1000);
        idle_gap_max = 250;
        test_random(400);

        write_base(32'hFFFF_FF00);
        idle_gap_max = 20;
        test_random(300);

        write_base($urandom);
        idle_gap_max = 60;
        test_random(300);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("bitmap_first_fit_allocator_tb: PASS");
        else
            $display("bitmap_first_fit_allocator_tb: FAIL");
        $finish;
    end

endmodule
